[hdl/assert_macros.svh]
// Assertion macros used by the checker file of the shuffle block.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted.
`define ASSERT_RST(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked assertion that is also checked during reset.
`define ASSERT_NORST(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[hdl/ssr_pkg.sv]
// Shared types and constants of the string shuffle block.
// No dependencies.
package ssr_pkg;

  localparam int unsigned CHAR_W    = 8;
  localparam int unsigned POS_W     = 8;
  localparam int unsigned RND_W     = 16;
  localparam int unsigned DIV_CNT_W = 4;

  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_DRAW = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_READ,
    ST_CHECK,
    ST_CLEAR
  } state_e;

  typedef struct packed {
    logic load;
    logic div_start;
    logic div_step;
    logic mem_read;
    logic place;
    logic clr_all;
    logic clr_len;
    logic clr_step;
  } cmd_t;

  typedef struct packed {
    logic ready;
    logic div_last;
    logic used;
    logic run_done;
    logic clr_last;
  } sts_t;

endpackage

[hdl/ssr_ctrl.sv]
// Controller state machine of the string shuffle block.
// Depends on ssr_pkg; drives the datapath through cmd_t, reads sts_t.
module ssr_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic          func_i,
  input  logic          load_last_i,
  input  ssr_pkg::sts_t sts_i,
  output ssr_pkg::cmd_t cmd_o,
  output logic          busy_o
);

  ssr_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ssr_pkg::ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ssr_pkg::ST_IDLE: begin
        if (start_i) begin
          if (func_i == ssr_pkg::FUNC_LOAD) begin
            cmd_o.load = 1'b1;
            if (load_last_i) begin
              cmd_o.clr_all = 1'b1;
              state_d       = ssr_pkg::ST_CLEAR;
            end
          end else if (sts_i.ready) begin
            cmd_o.div_start = 1'b1;
            state_d         = ssr_pkg::ST_DIV;
          end
        end
      end
      ssr_pkg::ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = ssr_pkg::ST_READ;
        end
      end
      ssr_pkg::ST_READ: begin
        cmd_o.mem_read = 1'b1;
        state_d        = ssr_pkg::ST_CHECK;
      end
      ssr_pkg::ST_CHECK: begin
        state_d = ssr_pkg::ST_IDLE;
        if (!sts_i.used) begin
          cmd_o.place = 1'b1;
          if (sts_i.run_done) begin
            cmd_o.clr_len = 1'b1;
            state_d       = ssr_pkg::ST_CLEAR;
          end
        end
      end
      ssr_pkg::ST_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_last) begin
          state_d = ssr_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = ssr_pkg::ST_IDLE;
      end
    endcase
  end

  assign busy_o = (state_q != ssr_pkg::ST_IDLE);

endmodule

[hdl/ssr_datapath.sv]
// Datapath of the string shuffle block: character store, used-mark store,
// serial modulo unit, counters and result registers. Depends on ssr_pkg.
module ssr_datapath #(
  parameter int unsigned MAX_LEN = 256
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  ssr_pkg::cmd_t              cmd_i,
  input  logic [ssr_pkg::CHAR_W-1:0] char_byte_i,
  input  logic                       load_last_i,
  input  logic [ssr_pkg::RND_W-1:0]  random_value_i,
  output ssr_pkg::sts_t              sts_o,
  output logic                       out_valid_o,
  output logic [ssr_pkg::CHAR_W-1:0] out_char_o,
  output logic [ssr_pkg::POS_W-1:0]  out_position_o,
  output logic                       run_last_o
);

  localparam int unsigned LEN_W = $clog2(MAX_LEN + 1);
  localparam int unsigned IDX_W = $clog2(MAX_LEN);
  localparam logic [LEN_W-1:0] MAX_LEN_L = LEN_W'(MAX_LEN);

  logic [ssr_pkg::CHAR_W-1:0] char_mem [MAX_LEN];
  logic                       used_mem [MAX_LEN];

  logic [LEN_W-1:0] len_q, len_d;
  logic [LEN_W-1:0] placed_q, placed_d;
  logic [LEN_W-1:0] load_cnt_q, load_cnt_d;
  logic             ready_q, ready_d;

  logic [LEN_W-1:0]             rem_q, rem_d;
  logic [ssr_pkg::RND_W-1:0]    dvd_q, dvd_d;
  logic [ssr_pkg::DIV_CNT_W-1:0] div_cnt_q, div_cnt_d;
  logic [LEN_W:0]               trial;

  logic [LEN_W-1:0] clr_cnt_q, clr_cnt_d;
  logic [LEN_W-1:0] clr_lim_q, clr_lim_d;

  logic [ssr_pkg::CHAR_W-1:0] char_rd_q;
  logic                       used_rd_q;

  logic                       out_valid_q;
  logic [ssr_pkg::CHAR_W-1:0] out_char_q;
  logic [ssr_pkg::POS_W-1:0]  out_pos_q;
  logic                       run_last_q;

  logic                       load_wr;
  logic                       run_done;
  logic [LEN_W+ssr_pkg::POS_W-1:0] placed_ext;

  assign load_wr    = cmd_i.load && (load_cnt_q < MAX_LEN_L);
  assign trial      = {rem_q, dvd_q[ssr_pkg::RND_W-1]};
  assign run_done   = (({1'b0, placed_q} + (LEN_W+1)'(1)) >= {1'b0, len_q});
  assign placed_ext = {{ssr_pkg::POS_W{1'b0}}, placed_q};

  always_comb begin
    len_d      = len_q;
    placed_d   = placed_q;
    load_cnt_d = load_cnt_q;
    ready_d    = ready_q;
    if (cmd_i.load) begin
      if (load_cnt_q == '0) begin
        ready_d  = 1'b0;
        placed_d = '0;
      end
      if (load_wr) begin
        load_cnt_d = load_cnt_q + LEN_W'(1);
      end
      if (load_last_i) begin
        len_d      = load_cnt_d;
        ready_d    = 1'b1;
        load_cnt_d = '0;
        placed_d   = '0;
      end
    end
    if (cmd_i.place) begin
      placed_d = run_done ? '0 : (placed_q + LEN_W'(1));
    end
  end

  always_comb begin
    rem_d     = rem_q;
    dvd_d     = dvd_q;
    div_cnt_d = div_cnt_q;
    if (cmd_i.div_start) begin
      rem_d     = '0;
      dvd_d     = random_value_i;
      div_cnt_d = '0;
    end else if (cmd_i.div_step) begin
      if (trial >= {1'b0, len_q}) begin
        rem_d = LEN_W'(trial - {1'b0, len_q});
      end else begin
        rem_d = trial[LEN_W-1:0];
      end
      dvd_d     = {dvd_q[ssr_pkg::RND_W-2:0], 1'b0};
      div_cnt_d = div_cnt_q + ssr_pkg::DIV_CNT_W'(1);
    end
  end

  always_comb begin
    clr_cnt_d = clr_cnt_q;
    clr_lim_d = clr_lim_q;
    if (cmd_i.clr_all) begin
      clr_cnt_d = '0;
      clr_lim_d = MAX_LEN_L;
    end else if (cmd_i.clr_len) begin
      clr_cnt_d = '0;
      clr_lim_d = len_q;
    end else if (cmd_i.clr_step) begin
      clr_cnt_d = clr_cnt_q + LEN_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q       <= '0;
      placed_q    <= '0;
      load_cnt_q  <= '0;
      ready_q     <= 1'b0;
      div_cnt_q   <= '0;
      clr_cnt_q   <= '0;
      clr_lim_q   <= MAX_LEN_L;
      out_valid_q <= 1'b0;
    end else begin
      len_q       <= len_d;
      placed_q    <= placed_d;
      load_cnt_q  <= load_cnt_d;
      ready_q     <= ready_d;
      div_cnt_q   <= div_cnt_d;
      clr_cnt_q   <= clr_cnt_d;
      clr_lim_q   <= clr_lim_d;
      out_valid_q <= cmd_i.place;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvd_q <= dvd_d;
    if (cmd_i.place) begin
      out_char_q <= char_rd_q;
      out_pos_q  <= placed_ext[ssr_pkg::POS_W-1:0];
      run_last_q <= run_done;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_wr) begin
      char_mem[load_cnt_q[IDX_W-1:0]] <= char_byte_i;
    end
    if (cmd_i.mem_read) begin
      char_rd_q <= char_mem[rem_q[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.place) begin
      used_mem[rem_q[IDX_W-1:0]] <= 1'b1;
    end else if (cmd_i.clr_step) begin
      used_mem[clr_cnt_q[IDX_W-1:0]] <= 1'b0;
    end
    if (cmd_i.mem_read) begin
      used_rd_q <= used_mem[rem_q[IDX_W-1:0]];
    end
  end

  assign sts_o.ready    = ready_q;
  assign sts_o.div_last = (div_cnt_q == ssr_pkg::DIV_CNT_W'(ssr_pkg::RND_W - 1));
  assign sts_o.used     = used_rd_q;
  assign sts_o.run_done = run_done;
  assign sts_o.clr_last = (clr_cnt_q == (clr_lim_q - LEN_W'(1)));

  assign out_valid_o    = out_valid_q;
  assign out_char_o     = out_char_q;
  assign out_position_o = out_pos_q;
  assign run_last_o     = run_last_q;

endmodule

[hdl/string_shuffle_rejection.sv]
// Top level of the string shuffle block: rejection-sampling permutation.
// Depends on ssr_pkg, ssr_ctrl and ssr_datapath.
//
// Usage:
//   A request is taken at a rising edge with start_i high and busy_o low.
//   func_i low loads char_byte_i into the next string slot; load_last_i
//   ends the string. func_i high is a draw with random_value_i.
//   A non-final load leaves busy_o low.
//   A final load starts a sweep of all MAX_LEN entries of the used-mark memory.
//   A draw on a held string runs in order: capture, the serial modulo
//   by the length over the 16 random bits (one remainder bit a cycle),
//   the mark and character memory read, then the check and mark placing.
//   A placed character shows on out_char_o / out_position_o / run_last_o
//   for one cycle with out_valid_o, the cycle after the check.
//   A draw hitting a used position or made without a string gives nothing.
//   After the draw that completes the shuffle, the marks up to the string
//   length are swept before busy_o drops.
//   After reset all MAX_LEN marks are swept, with busy_o high.
//   The receiver cannot stall; results are never held.
module string_shuffle_rejection #(
  parameter int unsigned MAX_LEN = 256
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  output logic                       busy_o,
  input  logic                       func_i,
  input  logic [ssr_pkg::CHAR_W-1:0] char_byte_i,
  input  logic                       load_last_i,
  input  logic [ssr_pkg::RND_W-1:0]  random_value_i,
  output logic                       out_valid_o,
  output logic [ssr_pkg::CHAR_W-1:0] out_char_o,
  output logic [ssr_pkg::POS_W-1:0]  out_position_o,
  output logic                       run_last_o
);

  ssr_pkg::cmd_t cmd;
  ssr_pkg::sts_t sts;

  ssr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .func_i      (func_i),
    .load_last_i (load_last_i),
    .sts_i       (sts),
    .cmd_o       (cmd),
    .busy_o      (busy_o)
  );

  ssr_datapath #(
    .MAX_LEN (MAX_LEN)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .char_byte_i    (char_byte_i),
    .load_last_i    (load_last_i),
    .random_value_i (random_value_i),
    .sts_o          (sts),
    .out_valid_o    (out_valid_o),
    .out_char_o     (out_char_o),
    .out_position_o (out_position_o),
    .run_last_o     (run_last_o)
  );

endmodule

[hdl/ssr_checker.sv]
// Port-level assertions of the string shuffle block, bound to its top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module ssr_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start_i,
  input logic busy_o,
  input logic func_i,
  input logic load_last_i,
  input logic out_valid_o
);

  `ASSERT_RST(a_result_after_busy, clk_i, rst_ni, out_valid_o |-> $past(busy_o), "result without work")
  `ASSERT_RST(a_single_strobe, clk_i, rst_ni, out_valid_o |=> !out_valid_o, "back-to-back results")
  `ASSERT_RST(a_load_one_cycle, clk_i, rst_ni, (start_i && !busy_o && !func_i && !load_last_i) |=> !busy_o, "byte load stalled")
  `ASSERT_RST(a_last_load_sweeps, clk_i, rst_ni, (start_i && !busy_o && !func_i && load_last_i) |=> busy_o, "no sweep after final load")
  `ASSERT_NORST(a_idle_no_result_in_reset, clk_i, !rst_ni |-> !out_valid_o, "result during reset")

endmodule

bind string_shuffle_rejection ssr_checker u_ssr_checker (.*);

[dv/string_shuffle_rejection_tb.sv]
// Self-checking bench for string_shuffle_rejection: loads strings, draws positions and
// compares every placed character with an in-bench prediction of the shuffle state.
// Depends on ssr_pkg and the string_shuffle_rejection top level.
module string_shuffle_rejection_tb;

  localparam int unsigned CHAR_W       = ssr_pkg::CHAR_W;
  localparam int unsigned POS_W        = ssr_pkg::POS_W;
  localparam int unsigned RND_W        = ssr_pkg::RND_W;
  localparam logic        FUNC_LOAD    = ssr_pkg::FUNC_LOAD;
  localparam logic        FUNC_DRAW    = ssr_pkg::FUNC_DRAW;

  localparam int unsigned MAX_LEN      = 256;
  localparam int unsigned N_REQUESTS   = 950;
  localparam int unsigned LIMIT_CYCLES = 1_000_000;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic [POS_W-1:0]  pos;
    logic              last;
  } placement_t;

  class shuffle_tracker;
    logic [CHAR_W-1:0] chars [MAX_LEN];
    bit                marks [MAX_LEN];
    logic [8:0]        str_len;
    logic [8:0]        placed;
    logic [8:0]        loaded;
    bit                ready;
    int unsigned       completions;
    int unsigned       errors;
    placement_t        placements_due [$];

    function new();
      clear_marks();
      str_len     = '0;
      loaded      = '0;
      ready       = 1'b0;
      completions = 0;
      errors      = 0;
    endfunction

    function void clear_marks();
      foreach (marks[i]) marks[i] = 1'b0;
      placed = '0;
    endfunction

    function void take_request(logic f, logic [CHAR_W-1:0] b, logic l,
                               logic [RND_W-1:0] r);
      logic [POS_W-1:0] p;
      logic             done;
      placement_t       due;
      if (f == FUNC_LOAD) begin
        if (loaded == 0) begin
          ready = 1'b0;
          clear_marks();
        end
        if (loaded < MAX_LEN) begin
          chars[loaded[7:0]] = b;
          loaded++;
        end
        if (l) begin
          str_len = loaded;
          ready   = 1'b1;
          loaded  = '0;
          clear_marks();
        end
      end else if (ready && str_len != 0) begin
        p = POS_W'(r % str_len);
        if (!marks[p]) begin
          marks[p] = 1'b1;
          done     = (placed + 9'd1 >= str_len);
          due.ch   = chars[p];
          due.pos  = placed[7:0];
          due.last = done;
          placements_due.push_back(due);
          placed++;
          if (done) begin
            clear_marks();
            completions++;
          end
        end
      end
    endfunction

    function void check_placement(logic [CHAR_W-1:0] ch, logic [POS_W-1:0] pos, logic last);
      placement_t due;
      if (placements_due.size() == 0) begin
        $error("unexpected result: out_char %0h out_position %0d run_last %0b", ch, pos, last);
        errors++;
        return;
      end
      due = placements_due.pop_front();
      if (ch !== due.ch) begin
        $error("out_char: expected %0h, got %0h", due.ch, ch);
        errors++;
      end
      if (pos !== due.pos) begin
        $error("out_position: expected %0d, got %0d", due.pos, pos);
        errors++;
      end
      if (last !== due.last) begin
        $error("run_last: expected %0b, got %0b", due.last, last);
        errors++;
      end
    endfunction
  endclass

  logic              clk_i          = 1'b0;
  logic              rst_ni;
  logic              start_i        = 1'b0;
  logic              func_i         = FUNC_LOAD;
  logic [CHAR_W-1:0] char_byte_i    = '0;
  logic              load_last_i    = 1'b0;
  logic [RND_W-1:0]  random_value_i = '0;
  logic              busy_o;
  logic              out_valid_o;
  logic [CHAR_W-1:0] out_char_o;
  logic [POS_W-1:0]  out_position_o;
  logic              run_last_o;

  shuffle_tracker sb = new();
  int unsigned    n_taken = 0;
  int unsigned    cycles  = 0;

  string_shuffle_rejection #(
    .MAX_LEN(MAX_LEN)
  ) u_top (
    .clk_i,
    .rst_ni,
    .start_i,
    .busy_o,
    .func_i,
    .char_byte_i,
    .load_last_i,
    .random_value_i,
    .out_valid_o,
    .out_char_o,
    .out_position_o,
    .run_last_o
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o) begin
      sb.check_placement(out_char_o, out_position_o, run_last_o);
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic send_request(input logic f, input logic [CHAR_W-1:0] b, input logic l,
                              input logic [RND_W-1:0] r);
    int unsigned idle_pct;
    int unsigned gap;
    idle_pct = (n_taken < N_REQUESTS / 3) ? 6 : (n_taken < 2 * N_REQUESTS / 3) ? 86 : 0;
    gap = 0;
    while ($urandom_range(99) < idle_pct && gap < 60) gap++;
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i        <= 1'b1;
    func_i         <= f;
    char_byte_i    <= b;
    load_last_i    <= l;
    random_value_i <= r;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    n_taken++;
    sb.take_request(f, b, l, r);
  endtask

  // aim hit_pct percent of draws at a free position, keep the rest fully random
  task automatic draw_once(input int unsigned hit_pct);
    int unsigned      p;
    int unsigned      len;
    int unsigned      k;
    logic [RND_W-1:0] val;
    val = RND_W'($urandom_range(0, 65535));
    if (sb.ready && $urandom_range(99) < hit_pct) begin
      len = sb.str_len;
      p   = $urandom_range(0, len - 1);
      while (sb.marks[p]) p = (p + 1) % len;
      k   = $urandom_range(0, (65535 - p) / len);
      val = RND_W'(p + k * len);
    end
    send_request(FUNC_DRAW, CHAR_W'($urandom), 1'($urandom), val);
  endtask

  task automatic load_string(input int unsigned len);
    for (int unsigned i = 0; i < len; i++) begin
      send_request(FUNC_LOAD, CHAR_W'($urandom), i == len - 1, RND_W'($urandom));
      if (i + 1 < len && $urandom_range(15) == 0) draw_once(0);
    end
  endtask

  task automatic shuffle_rounds(input int unsigned rounds, input int unsigned hit_pct);
    int unsigned goal;
    goal = sb.completions + rounds;
    while (sb.completions < goal) draw_once(hit_pct);
  endtask

  // hold requests until every placement due has come out
  task automatic drain();
    start_i <= 1'b0;
    do @(posedge clk_i); while (sb.placements_due.size() != 0);
  endtask

  initial begin
    int unsigned choice;
    int unsigned len;
    bit          long_done;
    rst_ni    <= 1'b0;
    long_done = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // draws with no string held
    send_request(FUNC_DRAW, 8'h00, 1'b0, 16'h0000);
    send_request(FUNC_DRAW, 8'hFF, 1'b1, 16'hFFFF);
    // one-byte string: every draw completes
    send_request(FUNC_LOAD, 8'h00, 1'b1, 16'hFFFF);
    send_request(FUNC_DRAW, 8'h00, 1'b0, 16'hFFFF);
    send_request(FUNC_DRAW, 8'hFF, 1'b1, 16'h0000);
    // three bytes with used-position drops and a restart
    send_request(FUNC_LOAD, 8'hFF, 1'b0, 16'h0000);
    send_request(FUNC_LOAD, 8'h00, 1'b0, 16'hFFFF);
    send_request(FUNC_LOAD, 8'hA5, 1'b1, 16'h0000);
    send_request(FUNC_DRAW, 8'h00, 1'b0, 16'h0000);
    send_request(FUNC_DRAW, 8'h00, 1'b0, 16'h0003);
    send_request(FUNC_DRAW, 8'h00, 1'b0, 16'hFFFF);
    send_request(FUNC_DRAW, 8'h00, 1'b0, 16'h0001);
    send_request(FUNC_DRAW, 8'h00, 1'b0, 16'hFFFE);
    send_request(FUNC_DRAW, 8'h00, 1'b0, 16'h0002);
    // new load in the middle of a shuffle, draw while loading
    send_request(FUNC_LOAD, 8'h5A, 1'b0, 16'h0000);
    send_request(FUNC_DRAW, 8'h00, 1'b0, 16'h1234);
    send_request(FUNC_LOAD, 8'hC3, 1'b1, 16'h0000);
    send_request(FUNC_DRAW, 8'h00, 1'b0, 16'hFFFF);
    send_request(FUNC_DRAW, 8'h00, 1'b0, 16'hFFFF);
    send_request(FUNC_DRAW, 8'h00, 1'b0, 16'h0000);
    drain();

    while (n_taken < N_REQUESTS) begin
      if (!long_done && n_taken > N_REQUESTS / 4) begin
        load_string($urandom_range(MAX_LEN, MAX_LEN + 8));
        shuffle_rounds(1, 90);
        long_done = 1'b1;
      end
      choice = $urandom_range(99);
      if (choice < 80) begin
        len = ($urandom_range(7) == 0) ? $urandom_range(9, 48) : $urandom_range(1, 8);
        load_string(len);
        shuffle_rounds($urandom_range(0, 2), $urandom_range(30, 90));
        repeat ($urandom_range(0, len)) draw_once(50);
      end else begin
        repeat ($urandom_range(1, 4)) begin
          send_request(1'($urandom), CHAR_W'($urandom), 1'($urandom), RND_W'($urandom));
        end
      end
      if ($urandom_range(24) == 0) drain();
    end

    drain();
    repeat (MAX_LEN + 40) @(posedge clk_i);
    if (sb.placements_due.size() != 0) begin
      $error("%0d placements never came out", sb.placements_due.size());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+hdl
hdl/ssr_pkg.sv
hdl/ssr_ctrl.sv
hdl/ssr_datapath.sv
hdl/string_shuffle_rejection.sv
hdl/ssr_checker.sv
dv/string_shuffle_rejection_tb.sv
